/* rtl/core/per_head_softplus_sigmoid_gating_core_defines.svh */
// ----------------------------------------------------------------------------
// per-head gating core assertion macros
// shared macros for the concurrent checks of the gating core
// ----------------------------------------------------------------------------
`ifndef PER_HEAD_SOFTPLUS_SIGMOID_GATING_CORE_DEFINES_SVH
`define PER_HEAD_SOFTPLUS_SIGMOID_GATING_CORE_DEFINES_SVH

// same-cycle implication, ignored while reset is held
`define PHSG_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("phsg check failed: same-cycle rule");

// next-cycle implication, ignored while reset is held
`define PHSG_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("phsg check failed: next-cycle rule");

`endif

/* rtl/core/phsg_pkg.sv */
// ----------------------------------------------------------------------------
// phsg_pkg
// shared constants, codes and types of the per-head gating core
// ----------------------------------------------------------------------------
`default_nettype none

package phsg_pkg;

    localparam int MAX_HEAD_COUNT = 256;
    localparam int TBL_DEPTH      = 256;
    localparam int HEAD_W         = 8;
    localparam int CNT_W          = 9;
    localparam int VAL_W          = 16;
    localparam int G_W            = 32;
    localparam int BETA_W         = 16;

    localparam int HEAD_LIMIT_I =
        (MAX_HEAD_COUNT < TBL_DEPTH) ? MAX_HEAD_COUNT : TBL_DEPTH;
    localparam logic [CNT_W-1:0] HEAD_LIMIT = CNT_W'(HEAD_LIMIT_I);

    // fixed point one and two at 48 fraction bits
    localparam logic [63:0] ONE_Q = 64'h0001_0000_0000_0000;
    localparam logic [63:0] TWO_Q = 64'h0002_0000_0000_0000;

    // series limits
    localparam logic [6:0] EXP_TERMS = 7'd40;
    localparam logic [6:0] LN_K_END  = 7'd80;

    // request codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_DATA = 1'b1;

    typedef enum logic [1:0] {
        EXP_SOFT,
        EXP_ALOG,
        EXP_BETA
    } t_exp_sel;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_EXP_SETUP,
        ST_PART_CHK,
        ST_PART_MUL,
        ST_PART_MUL_W,
        ST_PART_DIV,
        ST_PART_DIV_W,
        ST_PART_END,
        ST_POW_MUL,
        ST_POW_MUL_W,
        ST_EXP_END,
        ST_LN_DIV,
        ST_LN_DIV_W,
        ST_LN_SQ,
        ST_LN_SQ_W,
        ST_LN_MUL,
        ST_LN_MUL_W,
        ST_LN_DIV_P,
        ST_LN_DIV_P_W,
        ST_LN_END,
        ST_MAG_MUL,
        ST_MAG_MUL_W,
        ST_BETA_DIV,
        ST_BETA_DIV_W,
        ST_DONE
    } t_eng_state;

    typedef struct packed {
        logic              start;
        logic              take;
        logic signed [16:0] x;
        logic [VAL_W-1:0]  alog;
        logic [VAL_W-1:0]  b;
    } t_eng_req;

    typedef struct packed {
        logic              done;
        logic [G_W-1:0]    g;
        logic [BETA_W-1:0] beta;
    } t_eng_rsp;

endpackage

`default_nettype wire

/* rtl/core/phsg_ifs.sv */
// ----------------------------------------------------------------------------
// phsg channel interfaces
// request, result and configuration channels with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface phsg_req_if;
    import phsg_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic [HEAD_W-1:0]        head_index;
    logic signed [VAL_W-1:0]  alog_value;
    logic signed [VAL_W-1:0]  bias_value;
    logic signed [VAL_W-1:0]  a_value;
    logic signed [VAL_W-1:0]  b_value;
    logic                     last_element;

    modport source (output valid, req_type, head_index, alog_value, bias_value,
                    a_value, b_value, last_element, input ready);
    modport sink   (input valid, req_type, head_index, alog_value, bias_value,
                    a_value, b_value, last_element, output ready);
endinterface

interface phsg_res_if;
    import phsg_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [G_W-1:0]    g_value;
    logic [BETA_W-1:0]        beta_value;
    logic [HEAD_W-1:0]        head_used;
    logic                     last_out;

    modport source (output valid, g_value, beta_value, head_used, last_out,
                    input ready);
    modport sink   (input valid, g_value, beta_value, head_used, last_out,
                    output ready);
endinterface

interface phsg_cfg_if;
    import phsg_pkg::*;
    logic              valid;
    logic              ready;
    logic [CNT_W-1:0]  head_count;

    modport source (output valid, head_count, input ready);
    modport sink   (input valid, head_count, output ready);
endinterface

`default_nettype wire

/* rtl/core/phsg_ram.sv */
// ----------------------------------------------------------------------------
// phsg_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module phsg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/phsg_engine.sv */
// ----------------------------------------------------------------------------
// phsg_engine
// sequenced fixed-point unit: exp, ln(1+t), gate product and sigmoid
// ----------------------------------------------------------------------------
`default_nettype none

module phsg_engine (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire phsg_pkg::t_eng_req i_req,
    output phsg_pkg::t_eng_rsp     o_rsp
);
    import phsg_pkg::*;

    t_eng_state r_state, n_state;

    logic signed [16:0] r_x;
    logic [VAL_W-1:0]   r_alog, r_b;
    t_exp_sel           r_sel;
    logic               r_neg, r_base_ph;
    logic [4:0]         r_whole, r_pw;
    logic [12:0]        r_z;
    logic [6:0]         r_k;
    logic [63:0]        r_term, r_sum, r_r, r_base, r_sp, r_ea, r_p, r_w, r_s;
    logic [G_W-1:0]     r_g;
    logic [BETA_W-1:0]  r_beta;

    // multiplier: 64x64 as four 32x32 partial products
    logic          mul_go;
    logic [63:0]   mul_a, mul_b, mul_q;
    logic [63:0]   r_ma, r_mb, r_mpp;
    logic [127:0]  r_macc, pp_ext;
    logic [2:0]    r_mcnt;
    logic [1:0]    pp_idx;
    logic          r_mbusy, r_mdone;

    // divider: radix-2, 64 steps
    logic          div_go, dv_ge;
    logic [63:0]   div_hi, div_lo, div_d, dv_sh, dv_rem, beta_d;
    logic [63:0]   r_drem, r_dlo, r_dq, r_dd;
    logic [5:0]    r_dcnt;
    logic          r_dbusy, r_ddone;

    // exp set-up
    logic [16:0]   ex_m, xu;
    logic          ex_neg, x_pos;
    logic [32:0]   mag_q;
    logic [31:0]   mag;

    assign xu     = r_x;
    assign x_pos  = !r_x[16] && (r_x != 17'sd0);
    assign mul_q  = r_macc[111:48] + {63'd0, r_macc[47]};
    assign beta_d = ONE_Q + r_r;
    assign mag_q  = {13'd0, r_macc[127:108]} + {32'd0, r_macc[107]};
    assign mag    = (mag_q > 33'h0_8000_0000) ? 32'h8000_0000 : mag_q[31:0];

    always_comb begin
        unique case (r_sel)
            EXP_SOFT: begin
                ex_neg = 1'b1;
                ex_m   = r_x[16] ? (~xu + 17'd1) : xu;
            end
            EXP_ALOG: begin
                ex_neg = r_alog[15];
                ex_m   = {1'b0, r_alog[15] ? (~r_alog + 16'd1) : r_alog};
            end
            EXP_BETA: begin
                ex_neg = !r_b[15] && (r_b != 16'd0);
                ex_m   = {1'b0, r_b[15] ? (~r_b + 16'd1) : r_b};
            end
            default: begin
                ex_neg = 1'b0;
                ex_m   = 17'd0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:       if (i_req.start) n_state = ST_EXP_SETUP;
            ST_EXP_SETUP:  n_state = ST_PART_CHK;
            ST_PART_CHK: begin
                if (r_k == EXP_TERMS || r_term == 64'd0) n_state = ST_PART_END;
                else n_state = ST_PART_MUL;
            end
            ST_PART_MUL:   n_state = ST_PART_MUL_W;
            ST_PART_MUL_W: if (r_mdone) n_state = ST_PART_DIV;
            ST_PART_DIV:   n_state = ST_PART_DIV_W;
            ST_PART_DIV_W: if (r_ddone) n_state = ST_PART_CHK;
            ST_PART_END: begin
                if (r_base_ph) n_state = ST_POW_MUL;
                else if (r_whole == 5'd0) n_state = ST_EXP_END;
                else n_state = ST_PART_CHK;
            end
            ST_POW_MUL:    n_state = ST_POW_MUL_W;
            ST_POW_MUL_W: begin
                if (r_mdone) begin
                    n_state = (5'(r_pw + 5'd1) == r_whole) ? ST_EXP_END : ST_POW_MUL;
                end
            end
            ST_EXP_END: begin
                unique case (r_sel)
                    EXP_SOFT: n_state = ST_LN_DIV;
                    EXP_ALOG: n_state = ST_MAG_MUL;
                    EXP_BETA: n_state = ST_BETA_DIV;
                    default:  n_state = ST_IDLE;
                endcase
            end
            ST_LN_DIV:     n_state = ST_LN_DIV_W;
            ST_LN_DIV_W:   if (r_ddone) n_state = ST_LN_SQ;
            ST_LN_SQ:      n_state = ST_LN_SQ_W;
            ST_LN_SQ_W:    if (r_mdone) n_state = ST_LN_MUL;
            ST_LN_MUL:     n_state = (r_k >= LN_K_END) ? ST_LN_END : ST_LN_MUL_W;
            ST_LN_MUL_W: begin
                if (r_mdone) n_state = (mul_q == 64'd0) ? ST_LN_END : ST_LN_DIV_P;
            end
            ST_LN_DIV_P:   n_state = ST_LN_DIV_P_W;
            ST_LN_DIV_P_W: if (r_ddone) n_state = ST_LN_MUL;
            ST_LN_END:     n_state = ST_EXP_SETUP;
            ST_MAG_MUL:    n_state = ST_MAG_MUL_W;
            ST_MAG_MUL_W:  if (r_mdone) n_state = ST_EXP_SETUP;
            ST_BETA_DIV:   n_state = ST_BETA_DIV_W;
            ST_BETA_DIV_W: if (r_ddone) n_state = ST_DONE;
            ST_DONE:       if (i_req.take) n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
    end

    // unit launches
    always_comb begin
        mul_go = 1'b0;
        mul_a  = 64'd0;
        mul_b  = 64'd0;
        div_go = 1'b0;
        div_hi = 64'd0;
        div_lo = 64'd0;
        div_d  = 64'd0;
        unique case (r_state)
            ST_PART_MUL: begin
                mul_go = 1'b1;
                mul_a  = r_term;
                mul_b  = {51'd0, r_z};
            end
            ST_PART_DIV: begin
                div_go = 1'b1;
                div_lo = {12'd0, r_macc[63:12]};
                div_d  = {57'd0, r_k};
            end
            ST_POW_MUL: begin
                mul_go = 1'b1;
                mul_a  = r_r;
                mul_b  = r_base;
            end
            ST_LN_DIV: begin
                div_go = 1'b1;
                div_hi = {16'd0, r_r[63:16]};
                div_lo = {r_r[15:0], 48'd0};
                div_d  = TWO_Q + r_r;
            end
            ST_LN_SQ: begin
                mul_go = 1'b1;
                mul_a  = r_p;
                mul_b  = r_p;
            end
            ST_LN_MUL: begin
                mul_go = (r_k < LN_K_END);
                mul_a  = r_p;
                mul_b  = r_w;
            end
            ST_LN_DIV_P: begin
                div_go = 1'b1;
                div_lo = r_p;
                div_d  = {57'd0, r_k};
            end
            ST_MAG_MUL: begin
                mul_go = 1'b1;
                mul_a  = r_ea;
                mul_b  = r_sp;
            end
            ST_BETA_DIV: begin
                div_go = 1'b1;
                div_hi = 64'd2;
                div_lo = beta_d;
                div_d  = {beta_d[62:0], 1'b0};
            end
            default: ;
        endcase
    end

    always_comb begin
        o_rsp.done = (r_state == ST_DONE);
        o_rsp.g    = r_g;
        o_rsp.beta = r_beta;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (i_req.start) begin
                    r_x    <= i_req.x;
                    r_alog <= i_req.alog;
                    r_b    <= i_req.b;
                    r_sel  <= EXP_SOFT;
                end
            end
            ST_EXP_SETUP: begin
                r_neg     <= ex_neg;
                r_whole   <= ex_m[16:12];
                r_z       <= {1'b0, ex_m[11:0]};
                r_term    <= ONE_Q;
                r_sum     <= ONE_Q;
                r_k       <= 7'd1;
                r_base_ph <= 1'b0;
            end
            ST_PART_DIV_W: begin
                if (r_ddone) begin
                    r_term <= r_dq;
                    r_sum  <= (r_neg && r_k[0]) ? r_sum - r_dq : r_sum + r_dq;
                    r_k    <= r_k + 7'd1;
                end
            end
            ST_PART_END: begin
                if (!r_base_ph) begin
                    // fraction part done, now the series for one whole unit
                    r_r       <= r_sum;
                    r_z       <= 13'd4096;
                    r_term    <= ONE_Q;
                    r_sum     <= ONE_Q;
                    r_k       <= 7'd1;
                    r_base_ph <= 1'b1;
                end else begin
                    r_base <= r_sum;
                    r_pw   <= 5'd0;
                end
            end
            ST_POW_MUL_W: begin
                if (r_mdone) begin
                    r_r  <= mul_q;
                    r_pw <= r_pw + 5'd1;
                end
            end
            ST_EXP_END: begin
                if (r_sel == EXP_ALOG) r_ea <= r_r;
            end
            ST_LN_DIV_W: begin
                if (r_ddone) begin
                    r_p <= r_dq;
                    r_s <= r_dq;
                end
            end
            ST_LN_SQ_W: begin
                if (r_mdone) begin
                    r_w <= mul_q;
                    r_k <= 7'd3;
                end
            end
            ST_LN_MUL_W: begin
                if (r_mdone) r_p <= mul_q;
            end
            ST_LN_DIV_P_W: begin
                if (r_ddone) begin
                    r_s <= r_s + r_dq;
                    r_k <= r_k + 7'd2;
                end
            end
            ST_LN_END: begin
                r_sp  <= {r_s[62:0], 1'b0} + (x_pos ? {12'd0, r_x[15:0], 36'd0} : 64'd0);
                r_sel <= EXP_ALOG;
            end
            ST_MAG_MUL_W: begin
                if (r_mdone) begin
                    r_g   <= 32'd0 - mag;
                    r_sel <= EXP_BETA;
                end
            end
            ST_BETA_DIV_W: begin
                if (r_ddone) r_beta <= (r_dq > 64'd65535) ? 16'hFFFF : r_dq[15:0];
            end
            default: ;
        endcase
    end

    // multiplier control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_mdone <= 1'b0;
            r_mcnt  <= 3'd0;
        end else begin
            r_mdone <= r_mbusy && (r_mcnt == 3'd4);
            if (mul_go) begin
                r_mbusy <= 1'b1;
                r_mcnt  <= 3'd0;
            end else if (r_mbusy) begin
                r_mcnt <= r_mcnt + 3'd1;
                if (r_mcnt == 3'd4) r_mbusy <= 1'b0;
            end
        end
    end

    assign pp_idx = 2'(r_mcnt - 3'd1);

    always_comb begin
        unique case (pp_idx)
            2'd0:    pp_ext = {64'd0, r_mpp};
            2'd3:    pp_ext = {r_mpp, 64'd0};
            default: pp_ext = {32'd0, r_mpp, 32'd0};
        endcase
    end

    // multiplier datapath: product registered before it is summed
    always_ff @(posedge i_clk) begin
        if (mul_go) begin
            r_ma   <= mul_a;
            r_mb   <= mul_b;
            r_macc <= 128'd0;
        end else if (r_mbusy) begin
            if (r_mcnt != 3'd4) begin
                r_mpp <= (r_mcnt[0] ? r_ma[63:32] : r_ma[31:0])
                       * (r_mcnt[1] ? r_mb[63:32] : r_mb[31:0]);
            end
            if (r_mcnt != 3'd0) r_macc <= r_macc + pp_ext;
        end
    end

    // divider step
    assign dv_sh  = {r_drem[62:0], r_dlo[63]};
    assign dv_ge  = r_drem[63] || (dv_sh >= r_dd);
    assign dv_rem = dv_ge ? dv_sh - r_dd : dv_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_ddone <= 1'b0;
            r_dcnt  <= 6'd0;
        end else begin
            r_ddone <= r_dbusy && (r_dcnt == 6'd63);
            if (div_go) begin
                r_dbusy <= 1'b1;
                r_dcnt  <= 6'd0;
            end else if (r_dbusy) begin
                r_dcnt <= r_dcnt + 6'd1;
                if (r_dcnt == 6'd63) r_dbusy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_go) begin
            r_drem <= div_hi;
            r_dlo  <= div_lo;
            r_dd   <= div_d;
            r_dq   <= 64'd0;
        end else if (r_dbusy) begin
            r_drem <= dv_rem;
            r_dlo  <= {r_dlo[62:0], 1'b0};
            r_dq   <= {r_dq[62:0], dv_ge};
        end
    end

endmodule

`default_nettype wire

/* rtl/core/per_head_softplus_sigmoid_gating_core.sv */
// ----------------------------------------------------------------------------
// per_head_softplus_sigmoid_gating_core: g = -exp(alog[h])*softplus(a+bias[h]), beta
// load beat: next beat taken the cycle after; no result
// data beat: one item at a time, mostly spent in passes
//   of the shared radix-2 divider (one per series term); result waits in an output register
// reset: sync active low, clears head counter, head count (to 1) and handshakes; tables unset
// ----------------------------------------------------------------------------
`default_nettype none

module per_head_softplus_sigmoid_gating_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    phsg_req_if.sink   i_req,
    phsg_res_if.source o_res,
    phsg_cfg_if.sink   i_cfg
);
    import phsg_pkg::*;

    // configuration and head counter
    logic [CNT_W-1:0]  r_head_count;
    logic [CNT_W-1:0]  heads_eff, h_inc;
    logic [HEAD_W-1:0] r_head, n_head;

    // item in flight
    logic              r_busy, r_rd_pend;
    logic [VAL_W-1:0]  r_a, r_b;
    logic [HEAD_W-1:0] r_hsel;
    logic              r_last;

    // output register
    logic              r_out_valid;
    logic [G_W-1:0]    r_out_g;
    logic [BETA_W-1:0] r_out_beta;
    logic [HEAD_W-1:0] r_out_head;
    logic              r_out_last;

    logic              in_acc, load_acc, data_acc, take;
    logic [2*VAL_W-1:0] tbl_rdata;
    t_eng_req          eng_req;
    t_eng_rsp          eng_rsp;

    // one beat at a time; loads are blocked only while a data beat is in flight
    assign i_req.ready = !r_busy;
    assign in_acc      = i_req.valid && i_req.ready;
    assign load_acc    = in_acc && (i_req.req_type == REQ_LOAD);
    assign data_acc    = in_acc && (i_req.req_type == REQ_DATA);

    // configuration always accepted
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_count <= CNT_W'(1);
        end else if (i_cfg.valid) begin
            r_head_count <= i_cfg.head_count;
        end
    end

    // head count clamped to the table size, zero treated as one head
    always_comb begin
        if (r_head_count > HEAD_LIMIT) heads_eff = HEAD_LIMIT;
        else if (r_head_count == '0)   heads_eff = CNT_W'(1);
        else                           heads_eff = r_head_count;
    end

    // a counter left above a reduced head count wraps on the next data beat
    assign h_inc = {1'b0, r_head} + CNT_W'(1);

    always_comb begin
        if (i_req.last_element)   n_head = '0;
        else if (h_inc >= heads_eff) n_head = '0;
        else                      n_head = h_inc[HEAD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
        end else if (data_acc) begin
            r_head <= n_head;
        end
    end

    // head tables, alog in the upper half and bias in the lower half
    phsg_ram #(
        .WIDTH (2 * VAL_W),
        .DEPTH (TBL_DEPTH)
    ) u_tbl (
        .i_clk   (i_clk),
        .i_we    (load_acc),
        .i_waddr (i_req.head_index),
        .i_wdata ({i_req.alog_value, i_req.bias_value}),
        .i_re    (data_acc),
        .i_raddr (r_head),
        .o_rdata (tbl_rdata)
    );

    // data beat capture; table word arrives the cycle after
    always_ff @(posedge i_clk) begin
        if (data_acc) begin
            r_a    <= i_req.a_value;
            r_b    <= i_req.b_value;
            r_hsel <= r_head;
            r_last <= i_req.last_element;
        end
    end

    // output register free or being drained this cycle
    assign take = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_rd_pend <= 1'b0;
        end else begin
            r_rd_pend <= data_acc;
            if (data_acc) begin
                r_busy <= 1'b1;
            end else if (eng_rsp.done && take) begin
                r_busy <= 1'b0;
            end
        end
    end

    // engine launch with the sum of a and the head bias
    always_comb begin
        eng_req.start = r_rd_pend;
        eng_req.take  = take;
        eng_req.x     = $signed({r_a[VAL_W-1], r_a})
                      + $signed({tbl_rdata[VAL_W-1], tbl_rdata[VAL_W-1:0]});
        eng_req.alog  = tbl_rdata[2*VAL_W-1:VAL_W];
        eng_req.b     = r_b;
    end

    phsg_engine u_eng (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (eng_req),
        .o_rsp   (eng_rsp)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_rsp.done && take) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_rsp.done && take) begin
            r_out_g    <= eng_rsp.g;
            r_out_beta <= eng_rsp.beta;
            r_out_head <= r_hsel;
            r_out_last <= r_last;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.g_value    = r_out_g;
    assign o_res.beta_value = r_out_beta;
    assign o_res.head_used  = r_out_head;
    assign o_res.last_out   = r_out_last;

endmodule

`default_nettype wire

/* rtl/core/phsg_checker.sv */
// ----------------------------------------------------------------------------
// phsg_checker
// port-level checks of the gating core, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "per_head_softplus_sigmoid_gating_core_defines.svh"

module phsg_checker (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     i_req_valid,
    input wire logic                     i_req_ready,
    input wire logic                     i_req_type,
    input wire logic                     i_res_valid,
    input wire logic                     i_res_ready,
    input wire logic [phsg_pkg::G_W-1:0] i_g_value
);
    import phsg_pkg::*;

    // a stalled result beat stays offered
    `PHSG_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid)

    // a data beat blocks the input side while it is worked on
    `PHSG_ASSERT_NEXT(a_data_blocks, i_clk, i_rst_n, i_req_valid && i_req_ready && i_req_type == REQ_DATA, !i_req_ready)

    // a load beat never blocks the next beat
    `PHSG_ASSERT_NEXT(a_load_free, i_clk, i_rst_n, i_req_valid && i_req_ready && i_req_type == REQ_LOAD, i_req_ready)

    // the gate is never positive
    `PHSG_ASSERT_IMPL(a_g_nonpos, i_clk, i_rst_n, i_res_valid, i_g_value[G_W-1] || i_g_value == '0)

endmodule

bind per_head_softplus_sigmoid_gating_core phsg_checker u_phsg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_req_type  (i_req.req_type),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_g_value   (o_res.g_value)
);

`default_nettype wire
